>>> sv/lgce_pkg.sv
package lgce_pkg;

	localparam int CAP = 1024;
	localparam int SW  = $clog2(CAP);
	localparam int OW  = SW + 1;
	localparam int EW  = 6;

	localparam logic [EW-1:0] EVICT_RST = EW'(52);

	localparam logic [1:0] KIND_HIT   = 2'd0;
	localparam logic [1:0] KIND_MISS  = 2'd1;
	localparam logic [1:0] KIND_EVICT = 2'd2;
	localparam logic [1:0] KIND_FLUSH = 2'd3;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] grant_ref;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] ref_out;
		logic [9:0]  slot;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_SCAN,
		S_HRD,
		S_H1,
		S_H2,
		S_H3,
		S_EVRD,
		S_EVOUT,
		S_IRD,
		S_I1,
		S_I2,
		S_FIN
	} state_t;

endpackage

>>> sv/lgce_ram.sv
module lgce_ram #(
	parameter int W  = 32,
	parameter int D  = 1024,
	parameter int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/lgce_seq.sv
module lgce_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  lgce_pkg::req_t         req,
	input  logic [lgce_pkg::EW-1:0] evict_count,
	input  logic                   out_free,
	output logic                   emit,
	output lgce_pkg::rsp_t         emit_data
);
	import lgce_pkg::*;

	state_t        state_q, state_d;
	logic [OW-1:0] idx_q;
	logic          flush_q;
	logic          cmp_v_s1;
	logic [SW-1:0] cmp_idx_s1;
	logic [31:0]   ref_q;
	logic [SW-1:0] slot_q, nw_q, od_q, newest_q, oldest_q;
	logic [OW-1:0] occ_q, top_q;
	logic [EW-1:0] left_q;
	rsp_t          fin_q;

	logic          tag_we, val_we, nwr_we, old_we, fre_we;
	logic [SW-1:0] tag_wa, val_wa, nwr_wa, old_wa, fre_wa;
	logic [31:0]   tag_wd;
	logic          val_wd;
	logic [SW-1:0] nwr_wd, old_wd, fre_wd;
	logic [SW-1:0] tag_ra, nwr_ra, old_ra, fre_ra;
	logic [31:0]   tag_rd;
	logic          val_rd;
	logic [SW-1:0] nwr_rd, old_rd, fre_rd;

	logic accept, hit, miss, ev_go, ev_end;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign hit  = (state_q == S_SCAN) && cmp_v_s1 && val_rd && (tag_rd == ref_q);
	assign miss = (state_q == S_SCAN) && !cmp_v_s1 && idx_q[SW];
	assign ev_go  = (state_q == S_EVOUT) && out_free;
	assign ev_end = (left_q <= EW'(1)) || (occ_q == OW'(1));

	assign tag_ra = (state_q == S_SCAN) ? idx_q[SW-1:0] : oldest_q;
	assign nwr_ra = (state_q == S_HRD) ? slot_q : oldest_q;
	assign old_ra = slot_q;
	assign fre_ra = top_q[SW-1:0] - SW'(1);

	lgce_ram #(.W(32), .D(CAP)) u_tag (.clk(clk), .we(tag_we), .waddr(tag_wa),
		.wdata(tag_wd), .raddr(tag_ra), .rdata(tag_rd));
	lgce_ram #(.W(1), .D(CAP)) u_val (.clk(clk), .we(val_we), .waddr(val_wa),
		.wdata(val_wd), .raddr(tag_ra), .rdata(val_rd));
	lgce_ram #(.W(SW), .D(CAP)) u_nwr (.clk(clk), .we(nwr_we), .waddr(nwr_wa),
		.wdata(nwr_wd), .raddr(nwr_ra), .rdata(nwr_rd));
	lgce_ram #(.W(SW), .D(CAP)) u_old (.clk(clk), .we(old_we), .waddr(old_wa),
		.wdata(old_wd), .raddr(old_ra), .rdata(old_rd));
	lgce_ram #(.W(SW), .D(CAP)) u_fre (.clk(clk), .we(fre_we), .waddr(fre_wa),
		.wdata(fre_wd), .raddr(fre_ra), .rdata(fre_rd));

	always_comb begin
		state_d   = state_q;
		tag_we    = 1'b0;
		tag_wa    = fre_rd;
		tag_wd    = ref_q;
		val_we    = 1'b0;
		val_wa    = idx_q[SW-1:0];
		val_wd    = 1'b0;
		nwr_we    = 1'b0;
		nwr_wa    = slot_q;
		nwr_wd    = slot_q;
		old_we    = 1'b0;
		old_wa    = slot_q;
		old_wd    = newest_q;
		fre_we    = 1'b0;
		fre_wa    = idx_q[SW-1:0];
		fre_wd    = ~idx_q[SW-1:0];
		emit      = 1'b0;
		emit_data = fin_q;
		case (state_q)
			S_CLR: begin
				val_we = 1'b1;
				fre_we = 1'b1;
				if (idx_q[SW-1:0] == SW'(CAP - 1)) begin
					state_d = flush_q ? S_FIN : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = (req.opcode == OP_FLUSH) ? S_CLR : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = (cmp_idx_s1 == newest_q) ? S_FIN : S_HRD;
				end else if (miss) begin
					state_d = occ_q[SW] ? S_EVRD : S_IRD;
				end
			end
			S_HRD: state_d = S_H1;
			S_H1: begin
				old_we = 1'b1;
				old_wa = nwr_rd;
				old_wd = old_rd;
				nwr_we = 1'b1;
				state_d = S_H2;
			end
			S_H2: begin
				old_we = 1'b1;
				nwr_we = (slot_q != oldest_q);
				nwr_wa = od_q;
				nwr_wd = nw_q;
				state_d = S_H3;
			end
			S_H3: begin
				nwr_we = 1'b1;
				nwr_wa = newest_q;
				state_d = S_FIN;
			end
			S_EVRD: state_d = S_EVOUT;
			S_EVOUT: begin
				emit_data = '{kind: KIND_EVICT, ref_out: tag_rd, slot: oldest_q, last: 1'b0};
				if (out_free) begin
					emit   = 1'b1;
					val_we = 1'b1;
					val_wa = oldest_q;
					fre_we = 1'b1;
					fre_wa = top_q[SW-1:0];
					fre_wd = oldest_q;
					state_d = ev_end ? S_IRD : S_EVRD;
				end
			end
			S_IRD: state_d = S_I1;
			S_I1: begin
				tag_we = 1'b1;
				val_we = 1'b1;
				val_wa = fre_rd;
				val_wd = 1'b1;
				nwr_we = 1'b1;
				nwr_wa = fre_rd;
				nwr_wd = fre_rd;
				old_we = 1'b1;
				old_wa = fre_rd;
				old_wd = (occ_q == '0) ? fre_rd : newest_q;
				state_d = S_I2;
			end
			S_I2: begin
				nwr_we = (occ_q != '0);
				nwr_wa = newest_q;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			flush_q  <= 1'b0;
			cmp_v_s1 <= 1'b0;
			newest_q <= '0;
			oldest_q <= '0;
			occ_q    <= '0;
			top_q    <= OW'(CAP);
			left_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					idx_q <= idx_q + OW'(1);
					if (idx_q[SW-1:0] == SW'(CAP - 1)) begin
						flush_q  <= 1'b0;
						top_q    <= OW'(CAP);
						occ_q    <= '0;
						newest_q <= '0;
						oldest_q <= '0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						cmp_v_s1 <= 1'b0;
						flush_q  <= (req.opcode == OP_FLUSH);
					end
				end
				S_SCAN: begin
					cmp_v_s1 <= !idx_q[SW];
					if (!idx_q[SW]) begin
						idx_q <= idx_q + OW'(1);
					end
					if (miss) begin
						left_q <= (evict_count == '0) ? EW'(1) : evict_count;
					end
				end
				S_H2: begin
					if (slot_q == oldest_q) begin
						oldest_q <= nw_q;
					end
				end
				S_H3: newest_q <= slot_q;
				S_EVOUT: begin
					if (ev_go) begin
						if (occ_q > OW'(1)) begin
							oldest_q <= nwr_rd;
						end
						occ_q  <= occ_q - OW'(1);
						top_q  <= top_q + OW'(1);
						left_q <= left_q - EW'(1);
					end
				end
				S_I2: begin
					if (occ_q == '0) begin
						oldest_q <= slot_q;
					end
					newest_q <= slot_q;
					occ_q    <= occ_q + OW'(1);
					top_q    <= top_q - OW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q[SW-1:0];
		if (accept) begin
			ref_q <= req.grant_ref;
			fin_q <= '{kind: KIND_FLUSH, ref_out: 32'd0, slot: 10'd0, last: 1'b1};
		end
		if (hit) begin
			slot_q <= cmp_idx_s1;
			fin_q  <= '{kind: KIND_HIT, ref_out: ref_q, slot: cmp_idx_s1, last: 1'b1};
		end
		if (state_q == S_H1) begin
			nw_q <= nwr_rd;
			od_q <= old_rd;
		end
		if (state_q == S_I1) begin
			slot_q <= fre_rd;
			fin_q  <= '{kind: KIND_MISS, ref_out: ref_q, slot: fre_rd, last: 1'b1};
		end
	end

endmodule

>>> sv/lru_grant_cache_batch_evict.sv
// LRU cache of 32-bit grant references with batch eviction, 1024 slots.
// Request channel: req_valid / req_stall carry one word {opcode, grant_ref}.
// Response channel: rsp_valid / rsp_stall carry {kind, ref_out, slot, last};
// last marks the final response word caused by one request word.
// cfg_we / cfg_wdata write evict_count (reset 52, zero acts as one).
// One request at a time: req_stall stays high until its last word is loaded.
// A lookup scans the tag memory one slot per cycle; a hit stops the scan at
// the matching slot, and a miss is found once all 1024 slots are compared.
// A hit then relinks in S_HRD, S_H1, S_H2, S_H3 (skipped if already newest),
// an insert runs S_IRD, S_I1, S_I2, and S_FIN then loads the final word.
// A full cache evicts on a miss (S_EVRD, S_EVOUT per entry) before inserting.
// A flush sweeps all 1024 slots, one per cycle, then returns one word.
// After reset the same sweep runs before the first request is
// taken; configuration writes are taken throughout.
// A stalled response word is held in the output register; the sequencer
// waits to emit while that register holds a stalled word.
module lru_grant_cache_batch_evict (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lgce_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lgce_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [5:0]     cfg_wdata
);
	import lgce_pkg::*;

	logic [EW-1:0] evict_q;
	logic          out_v_q;
	rsp_t          out_q;
	logic          out_free, emit;
	rsp_t          emit_data;

	assign out_free  = !out_v_q || !rsp_stall;
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	lgce_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.evict_count(evict_q),
		.out_free   (out_free),
		.emit       (emit),
		.emit_data  (emit_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evict_q <= EVICT_RST;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				evict_q <= cfg_wdata;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_data;
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

import lgce_pkg::*;

class lru_scoreboard;
	logic [31:0] tag[CAP];
	bit          live[CAP];
	int          newer[CAP];
	int          older[CAP];
	int          free_slots[CAP];
	int          newest, oldest, occ, free_top;
	int          evict_n;
	rsp_t        due[$];
	int          errors;

	function new();
		evict_n = EVICT_RST;
		errors = 0;
		for (int i = 0; i < CAP; i++) begin
			tag[i] = '0;
			newer[i] = 0;
			older[i] = 0;
		end
		clear();
	endfunction

	function void clear();
		for (int i = 0; i < CAP; i++) begin
			live[i] = 0;
			free_slots[i] = CAP - 1 - i;
		end
		free_top = CAP;
		occ = 0;
		newest = 0;
		oldest = 0;
	endfunction

	function void push(logic [1:0] k, logic [31:0] r, int s, logic l);
		rsp_t w;
		w.kind = k;
		w.ref_out = r;
		w.slot = s[9:0];
		w.last = l;
		due.push_back(w);
	endfunction

	function void link_front(int s);
		newer[s] = s;
		if (occ == 0) begin
			older[s] = s;
			oldest = s;
		end else begin
			older[s] = newest;
			newer[newest] = s;
		end
		newest = s;
	endfunction

	function void unlink(int s);
		int nw, od;
		nw = newer[s];
		od = older[s];
		if (s == newest) begin
			newest = od;
		end else begin
			older[nw] = od;
		end
		if (s == oldest) begin
			oldest = nw;
		end else begin
			newer[od] = nw;
		end
	endfunction

	function void note(req_t w);
		int n, s;
		if (w.opcode == OP_FLUSH) begin
			clear();
			push(KIND_FLUSH, '0, 0, 1'b1);
			return;
		end
		for (int i = 0; i < CAP; i++) begin
			if (live[i] && tag[i] == w.grant_ref) begin
				if (i != newest) begin
					unlink(i);
					occ--;
					link_front(i);
					occ++;
				end
				push(KIND_HIT, w.grant_ref, i, 1'b1);
				return;
			end
		end
		if (occ >= CAP) begin
			n = (evict_n == 0) ? 1 : evict_n;
			while (n > 0 && occ > 0) begin
				s = oldest;
				if (occ > 1) begin
					oldest = newer[s];
				end
				live[s] = 0;
				occ--;
				if (free_top < CAP) begin
					free_slots[free_top] = s;
					free_top = free_top + 1;
				end
				push(KIND_EVICT, tag[s], s, 1'b0);
				n--;
			end
		end
		free_top = free_top - 1;
		s = free_slots[free_top];
		tag[s] = w.grant_ref;
		live[s] = 1;
		link_front(s);
		occ++;
		push(KIND_MISS, w.grant_ref, s, 1'b1);
	endfunction

	function void check(rsp_t r);
		rsp_t e;
		if (due.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("unexpected word: kind %0d ref %h slot %0d last %0d",
					r.kind, r.ref_out, r.slot, r.last);
			end
			return;
		end
		e = due.pop_front();
		if (r !== e) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch: expected kind %0d ref %h slot %0d last %0d,",
					e.kind, e.ref_out, e.slot, e.last);
				$display("          got kind %0d ref %h slot %0d last %0d",
					r.kind, r.ref_out, r.slot, r.last);
			end
		end
	endfunction

	function logic [31:0] live_ref();
		int s;
		if (occ == 0) begin
			return $urandom;
		end
		s = $urandom_range(CAP - 1);
		while (!live[s]) begin
			s = (s + 1) % CAP;
		end
		return tag[s];
	endfunction
endclass

module testbench;
	logic       clk = 0;
	logic       arst_n = 0;
	logic       req_valid = 0;
	logic       req_stall;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 0;
	rsp_t       rsp;
	logic       cfg_we = 0;
	logic [5:0] cfg_wdata = '0;
	bit         calm = 0;
	int         quiet = 0;

	lru_scoreboard sb = new();

	lru_grant_cache_batch_evict uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			sb.check(rsp);
		end
		rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 18);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet > 20000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task send(input logic op, input logic [31:0] r);
		req_t w;
		w.opcode = op;
		w.grant_ref = r;
		while (!calm && $urandom_range(99) < 18) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!(req_valid && !req_stall));
		sb.note(w);
	endtask

	task drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.due.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
	endtask

	task set_evict(input int v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v[5:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.evict_n = v;
	endtask

	task mixed(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 45) begin
				send(OP_LOOKUP, sb.live_ref());
			end else begin
				send(OP_LOOKUP, $urandom);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send(OP_FLUSH, 32'h0);
		send(OP_LOOKUP, 32'h0);
		send(OP_LOOKUP, 32'h0);
		send(OP_LOOKUP, 32'hFFFF_FFFF);
		send(OP_LOOKUP, 32'h5A5A_A5A5);
		send(OP_LOOKUP, 32'h0);
		send(OP_LOOKUP, 32'hFFFF_FFFF);
		send(OP_LOOKUP, 32'h5A5A_A5A5);
		send(OP_LOOKUP, 32'hA5A5_5A5A);
		send(OP_FLUSH, 32'hFFFF_FFFF);
		send(OP_LOOKUP, 32'hFFFF_FFFF);
		send(OP_LOOKUP, 32'h8000_0001);
		send(OP_LOOKUP, 32'hFFFF_FFFF);

		set_evict(63);
		calm = 1;
		for (int i = 0; i < CAP + 4; i++) begin
			send(OP_LOOKUP, $urandom);
		end
		calm = 0;
		mixed(40);
		set_evict(0);
		mixed(90);
		set_evict(1);
		mixed(90);
		set_evict(52);
		mixed(90);
		set_evict(37);
		mixed(90);
		send(OP_FLUSH, $urandom);
		send(OP_LOOKUP, $urandom);

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

>>> files.f
sv/lgce_pkg.sv
sv/lgce_ram.sv
sv/lgce_seq.sv
sv/lru_grant_cache_batch_evict.sv
test/testbench.sv
